@@ hdl/kli_pkg.sv @@
`default_nettype none

package kli_pkg;

  localparam int MAX_KEYS_DEFAULT = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  typedef struct packed {
    logic               is_query;
    logic               wr_ok;
    logic [3:0]         key_index;
    logic [15:0]        tval;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               mirror;
  } cmd_t;

endpackage

`default_nettype wire

@@ hdl/kli_ram.sv @@
`default_nettype none

module kli_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/kli_front.sv @@
`default_nettype none

module kli_front #(
  parameter int MAX_KEYS = kli_pkg::MAX_KEYS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               kind,
  input  wire logic [3:0]         key_index,
  input  wire logic [15:0]        key_time,
  input  wire logic signed [15:0] key_x,
  input  wire logic signed [15:0] key_y,
  input  wire logic signed [15:0] key_z,
  input  wire logic [15:0]        query_time,
  input  wire logic               mirror_x,
  output kli_pkg::cmd_t           head,
  output logic                    head_valid,
  input  wire logic               head_pop
);
  import kli_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           slots [QUEUE_DEPTH];
  cmd_t           incoming;
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  // A query carries its clamped time in the time field.
  always_comb begin
    incoming.is_query  = kind;
    incoming.wr_ok     = 32'(key_index) < 32'(MAX_KEYS);
    incoming.key_index = key_index;
    if (kind) begin
      incoming.tval = (query_time > ONE_Q15) ? ONE_Q15 : query_time;
    end else begin
      incoming.tval = key_time;
    end
    incoming.x      = key_x;
    incoming.y      = key_y;
    incoming.z      = key_z;
    incoming.mirror = mirror_x;
  end

  assign full       = count == CW'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = head_pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!do_push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/kli_back.sv @@
`default_nettype none

module kli_back #(
  parameter int MAX_KEYS = kli_pkg::MAX_KEYS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               key_count_write,
  input  wire logic [4:0]         key_count,
  input  wire kli_pkg::cmd_t      cmd,
  input  wire logic               cmd_valid,
  output logic                    cmd_pop,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic signed [15:0]      out_z
);
  import kli_pkg::*;

  localparam int AW = $clog2(MAX_KEYS);
  localparam int NW = $clog2(MAX_KEYS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_ORD  = 4'd3;
  localparam logic [3:0] S_OCAP = 4'd4;
  localparam logic [3:0] S_FA   = 4'd5;
  localparam logic [3:0] S_FB   = 4'd6;
  localparam logic [3:0] S_FBW  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_ADD  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0]         state;
  logic [4:0]         count_reg;
  logic [NW-1:0]      n;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      off_addr;
  logic [15:0]        q;
  logic               mirror;
  logic [15:0]        tprev;
  logic [15:0]        num;
  logic [15:0]        den;
  logic [15:0]        rem;
  logic [15:0]        alpha;
  logic [3:0]         cnt;
  logic signed [15:0] a_x, a_y, a_z;
  logic signed [15:0] b_x, b_y, b_z;
  logic signed [33:0] prod_x, prod_y, prod_z;
  logic signed [15:0] res_x, res_y, res_z;
  logic               out_valid;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [15:0]        time_rdata;
  logic [47:0]        off_rdata;
  logic [AW-1:0]      off_raddr;
  logic [NW-1:0]      n_cur;
  logic               last;
  logic [15:0]        t;
  logic [16:0]        r2;
  logic signed [16:0] alpha_s;
  logic signed [16:0] diff_x, diff_y, diff_z;
  logic [18:0]        sum_x, sum_y, sum_z;
  logic signed [15:0] mx;

  assign ram_we    = (state == S_IDLE) && cmd_valid && !cmd.is_query && cmd.wr_ok;
  assign ram_waddr = AW'(cmd.key_index);
  assign off_raddr = (state == S_FB) ? idx : off_addr;
  assign cmd_pop   = (state == S_IDLE) && cmd_valid;

  kli_ram #(.WIDTH(16), .DEPTH(MAX_KEYS)) u_time_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.tval),
    .raddr (idx),
    .rdata (time_rdata)
  );

  kli_ram #(.WIDTH(48), .DEPTH(MAX_KEYS)) u_offset_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({cmd.x, cmd.y, cmd.z}),
    .raddr (off_raddr),
    .rdata (off_rdata)
  );

  always_comb begin
    if (32'(count_reg) > 32'(MAX_KEYS)) begin
      n_cur = NW'(MAX_KEYS);
    end else begin
      n_cur = NW'(count_reg);
    end
    t       = time_rdata;
    last    = (NW'(idx) + NW'(1)) == n;
    r2      = {rem, 1'b0};
    alpha_s = signed'({1'b0, alpha});
    diff_x  = 17'(b_x) - 17'(a_x);
    diff_y  = 17'(b_y) - 17'(a_y);
    diff_z  = 17'(b_z) - 17'(a_z);
    sum_x   = 19'(a_x) + prod_x[33:15];
    sum_y   = 19'(a_y) + prod_y[33:15];
    sum_z   = 19'(a_z) + prod_z[33:15];
    mx      = (res_x == 16'sh8000) ? 16'sh7FFF : -res_x;
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        q      <= cmd.tval;
        mirror <= cmd.mirror;
        n      <= n_cur;
        idx    <= '0;
        res_x  <= '0;
        res_y  <= '0;
        res_z  <= '0;
      end
      S_SCMP: begin
        tprev <= t;
        if (t >= q && idx != '0) begin
          off_addr <= idx - AW'(1);
          num      <= q - tprev;
          den      <= t - tprev;
        end else if (t >= q) begin
          off_addr <= '0;
        end else if (last) begin
          off_addr <= idx;
        end else begin
          idx <= idx + AW'(1);
        end
      end
      S_OCAP: begin
        res_x <= off_rdata[47:32];
        res_y <= off_rdata[31:16];
        res_z <= off_rdata[15:0];
      end
      S_FB: begin
        a_x <= off_rdata[47:32];
        a_y <= off_rdata[31:16];
        a_z <= off_rdata[15:0];
      end
      S_FBW: begin
        b_x   <= off_rdata[47:32];
        b_y   <= off_rdata[31:16];
        b_z   <= off_rdata[15:0];
        alpha <= {15'd0, num >= den};
        rem   <= (num >= den) ? num - den : num;
        cnt   <= 4'd14;
      end
      S_DIV: begin
        if (r2 >= {1'b0, den}) begin
          rem   <= 16'(r2 - {1'b0, den});
          alpha <= {alpha[14:0], 1'b1};
        end else begin
          rem   <= r2[15:0];
          alpha <= {alpha[14:0], 1'b0};
        end
        cnt <= cnt - 4'd1;
      end
      S_MUL: begin
        prod_x <= diff_x * alpha_s;
        prod_y <= diff_y * alpha_s;
        prod_z <= diff_z * alpha_s;
      end
      S_ADD: begin
        res_x <= sum_x[15:0];
        res_y <= sum_y[15:0];
        res_z <= sum_z[15:0];
      end
      default: begin
      end
    endcase
    if (state == S_FIN && (!out_valid || pop)) begin
      out_x <= mirror ? mx : res_x;
      out_y <= res_y;
      out_z <= res_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_reg <= '0;
      out_valid <= 1'b0;
    end else begin
      if (key_count_write) begin
        count_reg <= key_count;
      end
      if (pop && out_valid && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.is_query) begin
            state <= (n_cur == '0) ? S_FIN : S_SRD;
          end
        end
        S_SRD: begin
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (t >= q && idx != '0) begin
            state <= (t <= tprev) ? S_ORD : S_FA;
          end else if (t >= q || last) begin
            state <= S_ORD;
          end else begin
            state <= S_SRD;
          end
        end
        S_ORD: begin
          state <= S_OCAP;
        end
        S_OCAP: begin
          state <= S_FIN;
        end
        S_FA: begin
          state <= S_FB;
        end
        S_FB: begin
          state <= S_FBW;
        end
        S_FBW: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == 4'd0) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || pop) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign empty = !out_valid;

  a_alpha_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> alpha <= ONE_Q15)
    else $error("alpha above one");

  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_FBW |-> den != '0 && num <= den)
    else $error("bad divider operands");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SRD |-> NW'(idx) < n)
    else $error("key scan past key count");

  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_FIN && out_valid && !pop |=> state == S_FIN)
    else $error("result overwritten before its beat");

endmodule

`default_nettype wire

@@ hdl/keyframe_linear_interpolator.sv @@
`default_nettype none
// A keyframe write is stored in the key table when it leaves the queue and gives no result.
// A query scans the keys one by one on the single time-table read port, then runs the
// bit-serial 16-bit divider when it falls between two keys; one query at a time.
// A two-entry input queue takes new beats while a query is worked or a result waits.
// Reset clears the queues, the sequencer and key_count; the key table is not cleared.

module keyframe_linear_interpolator #(
  parameter int MAX_KEYS = kli_pkg::MAX_KEYS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               key_count_write,
  input  wire logic [4:0]         key_count,
  input  wire logic               push,
  output logic                    full,
  input  wire logic               kind,
  input  wire logic [3:0]         key_index,
  input  wire logic [15:0]        key_time,
  input  wire logic signed [15:0] key_x,
  input  wire logic signed [15:0] key_y,
  input  wire logic signed [15:0] key_z,
  input  wire logic [15:0]        query_time,
  input  wire logic               mirror_x,
  output logic                    empty,
  input  wire logic               pop,
  output logic signed [15:0]      out_x,
  output logic signed [15:0]      out_y,
  output logic signed [15:0]      out_z
);
  import kli_pkg::*;

  cmd_t head;
  logic head_valid;
  logic head_pop;

  kli_front #(.MAX_KEYS(MAX_KEYS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .kind       (kind),
    .key_index  (key_index),
    .key_time   (key_time),
    .key_x      (key_x),
    .key_y      (key_y),
    .key_z      (key_z),
    .query_time (query_time),
    .mirror_x   (mirror_x),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop)
  );

  kli_back #(.MAX_KEYS(MAX_KEYS)) u_back (
    .clk             (clk),
    .rst             (rst),
    .key_count_write (key_count_write),
    .key_count       (key_count),
    .cmd             (head),
    .cmd_valid       (head_valid),
    .cmd_pop         (head_pop),
    .empty           (empty),
    .pop             (pop),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z)
  );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int UNIT = int'(kli_pkg::ONE_Q15);
  localparam int MAX_KEYS = kli_pkg::MAX_KEYS_DEFAULT;
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_CYCLES = 100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int BEAT_TARGET = 920;

  typedef struct {
    logic               kind;
    logic [3:0]         idx;
    logic [15:0]        ktime;
    logic signed [15:0] kx;
    logic signed [15:0] ky;
    logic signed [15:0] kz;
    logic [15:0]        qtime;
    logic               mirror;
  } beat_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } offsets_t;

  class interp_scoreboard;
    int key_times[MAX_KEYS];
    int key_x[MAX_KEYS];
    int key_y[MAX_KEYS];
    int key_z[MAX_KEYS];
    int count;
    offsets_t pending_offsets[$];
    int errors;
    int writes;
    int queries;
    int checked;

    function new();
      count = 0;
      errors = 0;
      writes = 0;
      queries = 0;
      checked = 0;
    endfunction

    function void set_count(int v);
      count = v;
    endfunction

    function int lerp(int a, int b, int alpha);
      longint prod;
      prod = longint'(b - a) * longint'(alpha);
      return a + int'(prod >>> 15);
    endfunction

    function offsets_t interpolate(int q_in, logic mirror);
      int n, q, found, ta, tb, alpha, rx, ry, rz, src;
      offsets_t r;
      n = (count > MAX_KEYS) ? MAX_KEYS : count;
      q = (q_in > UNIT) ? UNIT : q_in;
      rx = 0;
      ry = 0;
      rz = 0;
      src = -1;
      if (n == 1) begin
        src = 0;
      end else if (n >= 2) begin
        found = n;
        for (int i = 0; i < n; i++) begin
          if (found == n && key_times[i] >= q) found = i;
        end
        if (found == 0) begin
          src = 0;
        end else if (found >= n) begin
          src = n - 1;
        end else begin
          ta = key_times[found - 1];
          tb = key_times[found];
          if (tb <= ta) begin
            src = found - 1;
          end else begin
            alpha = (((q > ta) ? q - ta : 0) * UNIT) / (tb - ta);
            if (alpha > UNIT) alpha = UNIT;
            rx = lerp(key_x[found - 1], key_x[found], alpha);
            ry = lerp(key_y[found - 1], key_y[found], alpha);
            rz = lerp(key_z[found - 1], key_z[found], alpha);
          end
        end
      end
      if (src >= 0) begin
        rx = key_x[src];
        ry = key_y[src];
        rz = key_z[src];
      end
      if (mirror) begin
        rx = -rx;
        if (rx > 32767) rx = 32767;
      end
      r.x = rx[15:0];
      r.y = ry[15:0];
      r.z = rz[15:0];
      return r;
    endfunction

    function void note_beat(beat_t b);
      if (b.kind == KIND_WRITE) begin
        key_times[b.idx] = b.ktime;
        key_x[b.idx] = b.kx;
        key_y[b.idx] = b.ky;
        key_z[b.idx] = b.kz;
        writes++;
      end else begin
        pending_offsets.push_back(interpolate(b.qtime, b.mirror));
        queries++;
      end
    endfunction

    function void check_beat(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      offsets_t e;
      if (pending_offsets.size() == 0) begin
        $error("Result beat with no query waiting: x=%0d y=%0d z=%0d",
               $signed(x), $signed(y), $signed(z));
        errors++;
        return;
      end
      e = pending_offsets.pop_front();
      checked++;
      if (e.x !== x) begin
        $error("out_x: expected %0d, actual %0d", $signed(e.x), $signed(x));
        errors++;
      end
      if (e.y !== y) begin
        $error("out_y: expected %0d, actual %0d", $signed(e.y), $signed(y));
        errors++;
      end
      if (e.z !== z) begin
        $error("out_z: expected %0d, actual %0d", $signed(e.z), $signed(z));
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic key_count_write = 1'b0;
  logic [4:0] key_count = '0;
  logic push = 1'b0;
  logic full;
  logic kind = 1'b0;
  logic [3:0] key_index = '0;
  logic [15:0] key_time = '0;
  logic signed [15:0] key_x = '0;
  logic signed [15:0] key_y = '0;
  logic signed [15:0] key_z = '0;
  logic [15:0] query_time = '0;
  logic mirror_x = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;

  interp_scoreboard sb = new();
  bit no_idle = 1'b0;
  int hold_seq = 0;
  int beats_sent = 0;
  int cycles = 0;

  keyframe_linear_interpolator dut (
    .clk(clk),
    .rst(rst),
    .key_count_write(key_count_write),
    .key_count(key_count),
    .push(push),
    .full(full),
    .kind(kind),
    .key_index(key_index),
    .key_time(key_time),
    .key_x(key_x),
    .key_y(key_y),
    .key_z(key_z),
    .query_time(query_time),
    .mirror_x(mirror_x),
    .empty(empty),
    .pop(pop),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [15:0] rand_offset();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic beat_t make_write(int idx, int t, logic [15:0] x, logic [15:0] y,
                                       logic [15:0] z);
    beat_t b;
    b.kind = KIND_WRITE;
    b.idx = idx[3:0];
    b.ktime = t[15:0];
    b.kx = x;
    b.ky = y;
    b.kz = z;
    b.qtime = 16'($urandom);
    b.mirror = 1'($urandom);
    return b;
  endfunction

  function automatic beat_t make_query(int qt, logic mirror);
    beat_t b;
    b.kind = KIND_QUERY;
    b.idx = 4'($urandom);
    b.ktime = 16'($urandom);
    b.kx = 16'($urandom);
    b.ky = 16'($urandom);
    b.kz = 16'($urandom);
    b.qtime = qt[15:0];
    b.mirror = mirror;
    return b;
  endfunction

  task automatic send_beat(beat_t b);
    while (!no_idle && $urandom_range(0, 99) < 34) begin
      @(negedge clk);
      push = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    kind = b.kind;
    key_index = b.idx;
    key_time = b.ktime;
    key_x = b.kx;
    key_y = b.ky;
    key_z = b.kz;
    query_time = b.qtime;
    mirror_x = b.mirror;
    push = 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_beat(b);
    beats_sent++;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    push = 1'b0;
    while (sb.pending_offsets.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic set_key_count(int v);
    @(negedge clk);
    key_count_write = 1'b1;
    key_count = v[4:0];
    @(posedge clk);
    sb.set_count(v);
    @(negedge clk);
    key_count_write = 1'b0;
  endtask

  initial begin
    int hold_seen, hold_left;
    hold_seen = 0;
    hold_left = 0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else begin
        pop = no_idle || ($urandom_range(0, 99) >= 34);
      end
      @(posedge clk);
      if (pop && !empty) sb.check_beat(out_x, out_y, out_z);
    end
  end

  initial begin
    int set_no, n, n_eff, nq, t, mode, r, qt, settings;
    int times[$];
    set_no = 0;
    settings = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // No keys yet: every query returns zero.
    send_beat(make_query(0, 1'b0));
    send_beat(make_query(65535, 1'b1));
    send_beat(make_write(0, 0, 16'h8000, 16'h7fff, 16'hffff));
    send_beat(make_write(1, 16384, 16'h7fff, 16'h8000, 16'h5555));
    send_beat(make_write(2, 16384, 16'd100, -16'sd100, 16'h0000));
    send_beat(make_write(3, UNIT, 16'hffff, 16'h0001, 16'h8000));
    wait_quiet();
    set_key_count(1);
    settings++;
    send_beat(make_query(20000, 1'b1));
    send_beat(make_query(0, 1'b0));
    wait_quiet();
    set_key_count(4);
    settings++;
    send_beat(make_query(0, 1'b0));
    send_beat(make_query(8192, 1'b1));
    send_beat(make_query(16384, 1'b0));
    send_beat(make_query(20000, 1'b1));
    send_beat(make_query(65535, 1'b0));
    send_beat(make_query(UNIT, 1'b1));
    wait_quiet();
    set_key_count(3);
    settings++;
    send_beat(make_query(40000, 1'b0));
    send_beat(make_query(16385, 1'b1));

    while (beats_sent < BEAT_TARGET) begin
      wait_quiet();
      r = $urandom_range(0, 19);
      if (set_no == 0) n = MAX_KEYS;
      else if (set_no == 1) n = 31;
      else if (set_no == 2) n = 0;
      else if (r == 0) n = $urandom_range(MAX_KEYS + 1, 31);
      else if (r < 4) n = MAX_KEYS;
      else if (r < 6) n = $urandom_range(0, 1);
      else n = $urandom_range(2, 8);
      set_key_count(n);
      settings++;
      n_eff = (n > MAX_KEYS) ? MAX_KEYS : n;
      no_idle = (set_no >= 6 && set_no < 10);
      if (set_no == 3) hold_seq++;
      nq = (set_no == 3) ? 40 : $urandom_range(8, 30);

      times.delete();
      mode = $urandom_range(0, 9);
      for (int i = 0; i < n_eff; i++) begin
        if (mode < 2) t = 8192 * $urandom_range(0, 4);
        else t = $urandom_range(0, UNIT);
        times.push_back(t);
      end
      if (mode != 9) times.sort();
      if (n_eff > 0 && $urandom_range(0, 3) == 0) times[0] = 0;
      if (n_eff > 0 && $urandom_range(0, 3) == 0) times[n_eff - 1] = UNIT;
      for (int i = 0; i < n_eff; i++) begin
        send_beat(make_write(i, times[i], rand_offset(), rand_offset(), rand_offset()));
      end

      for (int j = 0; j < nq; j++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_beat(make_write($urandom_range(0, MAX_KEYS - 1), $urandom_range(0, UNIT),
                               rand_offset(), rand_offset(), rand_offset()));
        end else begin
          r = $urandom_range(0, 99);
          if (n_eff > 0 && r < 30) begin
            qt = times[$urandom_range(0, n_eff - 1)] + $urandom_range(0, 2) - 1;
            if (qt < 0) qt = 0;
          end else if (r < 45) begin
            qt = $urandom_range(0, 65535);
          end else if (r < 55) begin
            case ($urandom_range(0, 2))
              0: qt = 0;
              1: qt = UNIT;
              default: qt = 65535;
            endcase
          end else begin
            qt = $urandom_range(0, UNIT);
          end
          send_beat(make_query(qt, 1'($urandom)));
        end
      end
      set_no++;
    end

    no_idle = 1'b0;
    wait_quiet();
    $display("Checked %0d results from %0d queries and %0d key writes over %0d settings.",
             sb.checked, sb.queries, sb.writes, settings);
    $display("Both sides stalled at random; one long result hold-off backed up the input.");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
